FILE: hdl/ip_layer3_header_parser_macros.svh
// Assertion macros used by the layer-3 header parser RTL.
`ifndef IP_LAYER3_HEADER_PARSER_MACROS_SVH
`define IP_LAYER3_HEADER_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled while reset is asserted
`define L3HP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define L3HP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define L3HP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define L3HP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/l3hp_pkg.sv
// Types, codes and helper functions for the layer-3 header parser.
`timescale 1ns / 1ps
`default_nettype none
package l3hp_pkg;

    localparam int LEN_BITS_DEF = 16;

    // layer-3 type codes (hint and result)
    localparam logic [2:0] NET_UNSPEC     = 3'd0;
    localparam logic [2:0] NET_V4_UNSPEC  = 3'd1;
    localparam logic [2:0] NET_V4_OPTS    = 3'd2;
    localparam logic [2:0] NET_V4_NOOPTS  = 3'd3;
    localparam logic [2:0] NET_V6_UNSPEC  = 3'd4;
    localparam logic [2:0] NET_V6_EXT     = 3'd5;
    localparam logic [2:0] NET_V6_NOEXT   = 3'd6;
    localparam logic [2:0] NET_INVALID    = 3'd7;

    // layer-4 type codes
    localparam logic [1:0] L4_UNSPEC = 2'd0;
    localparam logic [1:0] L4_TCP    = 2'd1;
    localparam logic [1:0] L4_UDP    = 2'd2;
    localparam logic [1:0] L4_OTHER  = 2'd3;

    // protocol / next-header numbers
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0] PROTO_NONXT  = 8'd59;

    localparam logic [3:0] VER_IPV4 = 4'd4;
    localparam logic [3:0] VER_IPV6 = 4'd6;

    // byte offsets and sizes
    localparam int POS_VER_IHL   = 0;
    localparam int POS_V6_NEXT   = 6;
    localparam int POS_V4_PROTO  = 9;
    localparam int V4_MIN_BYTES  = 20;
    localparam int V6_HDR_BYTES  = 40;

    // extension header walk phase
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WANT_NEXT = 2'd1;
    localparam logic [1:0] PH_WANT_LEN  = 2'd2;
    localparam logic [1:0] PH_DONE      = 2'd3;

    typedef struct packed {
        logic [2:0] hint;
        logic       null_link;
        logic [1:0] transport;
        logic [7:0] ver_ihl;
        logic [7:0] v4_proto;
        logic [7:0] v6_next;
        logic [7:0] ext_next;
        logic [1:0] phase;
    } t_ctx;

    typedef struct packed {
        logic        ok;
        logic [2:0]  net;
        logic [1:0]  l4;
        logic [15:0] hdr_len;
    } t_result;

    function automatic logic v6_direct(input logic [7:0] nh);
        return (nh == PROTO_TCP) || (nh == PROTO_UDP) || (nh == PROTO_ICMP) ||
               (nh == PROTO_ICMPV6) || (nh == PROTO_NONXT);
    endfunction

    function automatic logic [1:0] map_l4(input logic [7:0] proto, input logic [1:0] preset);
        logic [1:0] r;
        r = preset;
        if (proto == PROTO_TCP) r = L4_TCP;
        else if (proto == PROTO_UDP) r = L4_UDP;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ip_layer3_header_parser.sv
// Pipe: input register -> capture/classify -> result register, which presents result beats.
// One byte beat per cycle while the sink does not hold a result beat.
// Only beats with tlast set produce a result; the result register stalls the whole pipe.
// Reset (i_rst_n low, synchronous) clears the pipe valids and all parser state at once.
// Bytes seen before any first_byte are counted from zero with an unspecified hint.
`timescale 1ns / 1ps
`default_nettype none
`include "ip_layer3_header_parser_macros.svh"
module ip_layer3_header_parser #(
    parameter int LEN_BITS = l3hp_pkg::LEN_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // byte stream in
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [7:0]   i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tlast,   // last_byte
    input  wire [6:0]   i_s_tuser,   // [0] first_byte, [3:1] type_hint,
                                     // [4] link_is_null, [6:5] preset_transport
    // parse result out
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata    // [0] parse_ok, [3:1] net_type,
                                     // [5:4] transport_type, [21:6] header_length, [23:22] 0
);
    import l3hp_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [6:0]  r_in_user;

    // result stage
    logic        r_out_valid;
    t_result     r_out_res;

    logic                w_adv;
    t_ctx                w_ctx;
    logic [LEN_BITS-1:0] w_pos;
    logic [LEN_BITS-1:0] w_ext;
    t_result             w_res;

    // whole pipe moves unless a result beat is held by the sink
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
            r_in_user <= i_s_tuser;
        end
    end

    l3hp_capture #(
        .LEN_BITS (LEN_BITS)
    ) u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv && r_in_valid),
        .i_byte   (r_in_byte),
        .i_first  (r_in_user[0]),
        .i_hint   (r_in_user[3:1]),
        .i_null   (r_in_user[4]),
        .i_preset (r_in_user[6:5]),
        .o_ctx    (w_ctx),
        .o_pos    (w_pos),
        .o_ext    (w_ext)
    );

    // classification sees the state as updated by the current byte
    l3hp_classify #(
        .LEN_BITS (LEN_BITS)
    ) u_classify (
        .i_ctx (w_ctx),
        .i_len (w_pos),
        .i_ext (w_ext),
        .o_res (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid && r_in_last) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_res.hdr_len, r_out_res.l4, r_out_res.net, r_out_res.ok};

    // a last beat in the input stage always turns into a result beat
    `L3HP_ASSERT_NXT(a_last_gives_result, i_clk, i_rst_n, w_adv && r_in_valid && r_in_last, r_out_valid, "last beat produced no result")
    // failed parse reports zero header length
    `L3HP_ASSERT_IMP(a_fail_zero_len, i_clk, i_rst_n, r_out_valid && !r_out_res.ok, r_out_res.hdr_len == 16'd0, "failed parse with nonzero length")
    // IPv4 without options is exactly the minimum header
    `L3HP_ASSERT_IMP(a_v4_noopts_len, i_clk, i_rst_n, r_out_valid && r_out_res.ok && r_out_res.net == NET_V4_NOOPTS, r_out_res.hdr_len == 16'(V4_MIN_BYTES), "IPv4 no-options length mismatch")
    // IPv6 without extensions is exactly the fixed header
    `L3HP_ASSERT_IMP(a_v6_noext_len, i_clk, i_rst_n, r_out_valid && r_out_res.ok && r_out_res.net == NET_V6_NOEXT, r_out_res.hdr_len == 16'(V6_HDR_BYTES), "IPv6 no-extension length mismatch")

endmodule
`default_nettype wire

FILE: hdl/l3hp_capture.sv
// Per-packet byte counter, field capture and IPv6 extension header walker.
`timescale 1ns / 1ps
`default_nettype none
module l3hp_capture #(
    parameter int LEN_BITS = l3hp_pkg::LEN_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire [7:0]           i_byte,
    input  wire                 i_first,
    input  wire [2:0]           i_hint,
    input  wire                 i_null,
    input  wire [1:0]           i_preset,
    output l3hp_pkg::t_ctx      o_ctx,
    output logic [LEN_BITS-1:0] o_pos,
    output logic [LEN_BITS-1:0] o_ext
);
    import l3hp_pkg::*;

    localparam int SUM_W = LEN_BITS + 12;
    localparam logic [LEN_BITS-1:0] MAX_POS = '1;

    t_ctx                r_ctx, n_ctx;
    logic [LEN_BITS-1:0] r_pos, n_pos;
    logic [LEN_BITS-1:0] r_ext, n_ext;
    logic [SUM_W-1:0]    w_end;

    always_comb begin
        n_ctx = r_ctx;
        n_pos = r_pos;
        n_ext = r_ext;
        if (i_first) begin
            n_ctx.hint      = i_hint;
            n_ctx.null_link = i_null;
            n_ctx.transport = i_preset;
            n_ctx.ver_ihl   = '0;
            n_ctx.v4_proto  = '0;
            n_ctx.v6_next   = '0;
            n_ctx.ext_next  = '0;
            n_ctx.phase     = PH_IDLE;
            n_pos           = '0;
            n_ext           = LEN_BITS'(V6_HDR_BYTES);
        end
        w_end = SUM_W'(n_ext) + SUM_W'(8) + (SUM_W'(i_byte) << 3);
        // saturated count: byte neither counted nor captured
        if (n_pos != MAX_POS) begin
            if (n_pos == LEN_BITS'(POS_VER_IHL)) n_ctx.ver_ihl = i_byte;
            if (n_pos == LEN_BITS'(POS_V4_PROTO)) n_ctx.v4_proto = i_byte;
            if (n_pos == LEN_BITS'(POS_V6_NEXT)) begin
                n_ctx.v6_next = i_byte;
                n_ctx.phase   = (!v6_direct(i_byte) && n_ctx.transport == L4_UNSPEC) ?
                                PH_WANT_NEXT : PH_IDLE;
                n_ext         = LEN_BITS'(V6_HDR_BYTES);
                w_end         = SUM_W'(n_ext) + SUM_W'(8) + (SUM_W'(i_byte) << 3);
            end
            if (n_ctx.phase == PH_WANT_NEXT && n_pos == n_ext) begin
                n_ctx.ext_next = i_byte;
                n_ctx.phase    = PH_WANT_LEN;
            end else if (n_ctx.phase == PH_WANT_LEN &&
                         {1'b0, n_pos} == ({1'b0, n_ext} + (LEN_BITS+1)'(1))) begin
                n_ext = (w_end > SUM_W'(MAX_POS)) ? MAX_POS : w_end[LEN_BITS-1:0];
                if (n_ctx.ext_next == PROTO_TCP || n_ctx.ext_next == PROTO_UDP ||
                    n_ctx.ext_next == PROTO_NONXT)
                    n_ctx.phase = PH_DONE;
                else
                    n_ctx.phase = PH_WANT_NEXT;
            end
            n_pos = n_pos + LEN_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '0;
            r_pos <= '0;
            r_ext <= LEN_BITS'(V6_HDR_BYTES);
        end else if (i_en) begin
            r_ctx <= n_ctx;
            r_pos <= n_pos;
            r_ext <= n_ext;
        end
    end

    assign o_ctx = n_ctx;
    assign o_pos = n_pos;
    assign o_ext = n_ext;

endmodule
`default_nettype wire

FILE: hdl/l3hp_classify.sv
// IPv4 / IPv6 decision from captured fields and the available length.
`timescale 1ns / 1ps
`default_nettype none
module l3hp_classify #(
    parameter int LEN_BITS = l3hp_pkg::LEN_BITS_DEF
) (
    input  l3hp_pkg::t_ctx      i_ctx,
    input  wire [LEN_BITS-1:0]  i_len,
    input  wire [LEN_BITS-1:0]  i_ext,
    output l3hp_pkg::t_result   o_res
);
    import l3hp_pkg::*;

    logic [LEN_BITS-1:0] w_v4_len;
    logic                w_v4_ok, w_v6_ok;
    logic [2:0]          w_v4_net, w_v6_net;
    logic [1:0]          w_v4_l4, w_v6_l4;
    logic [31:0]         w_v6_len;

    always_comb begin
        w_v4_len = LEN_BITS'({i_ctx.ver_ihl[3:0], 2'b00});
        w_v4_ok  = (i_len >= LEN_BITS'(V4_MIN_BYTES)) && (i_ctx.ver_ihl[7:4] == VER_IPV4) &&
                   (w_v4_len <= i_len);
        w_v4_net = (w_v4_len == LEN_BITS'(V4_MIN_BYTES)) ? NET_V4_NOOPTS : NET_V4_OPTS;
        w_v4_l4  = map_l4(i_ctx.v4_proto, i_ctx.transport);

        w_v6_ok  = 1'b0;
        w_v6_net = NET_V6_EXT;
        w_v6_l4  = i_ctx.transport;
        w_v6_len = 32'(V6_HDR_BYTES);
        if (i_len >= LEN_BITS'(V6_HDR_BYTES) && i_ctx.ver_ihl[7:4] == VER_IPV6) begin
            if (v6_direct(i_ctx.v6_next)) begin
                w_v6_ok  = 1'b1;
                w_v6_net = NET_V6_NOEXT;
                w_v6_l4  = map_l4(i_ctx.v6_next, i_ctx.transport);
            end else if (i_ctx.transport != L4_UNSPEC) begin
                w_v6_ok = 1'b1;
            end else if (i_ctx.phase == PH_DONE && i_ext <= i_len) begin
                w_v6_ok  = 1'b1;
                w_v6_l4  = map_l4(i_ctx.ext_next, i_ctx.transport);
                w_v6_len = 32'(i_ext);
            end
        end

        o_res.ok      = 1'b0;
        o_res.net     = i_ctx.hint;
        o_res.l4      = i_ctx.transport;
        o_res.hdr_len = '0;
        case (i_ctx.hint)
            NET_UNSPEC: begin
                if (i_ctx.null_link) begin
                    o_res.ok = 1'b1;
                    if (w_v4_ok) begin
                        o_res.net     = w_v4_net;
                        o_res.l4      = w_v4_l4;
                        o_res.hdr_len = 16'(w_v4_len);
                    end else if (w_v6_ok) begin
                        o_res.net     = w_v6_net;
                        o_res.l4      = w_v6_l4;
                        o_res.hdr_len = (w_v6_len > 32'hFFFF) ? 16'hFFFF : w_v6_len[15:0];
                    end else begin
                        // neither version matched: pass through untyped
                        o_res.net = NET_UNSPEC;
                    end
                end
            end
            NET_V4_UNSPEC, NET_V4_OPTS, NET_V4_NOOPTS: begin
                if (w_v4_ok) begin
                    o_res.ok      = 1'b1;
                    o_res.net     = w_v4_net;
                    o_res.l4      = w_v4_l4;
                    o_res.hdr_len = 16'(w_v4_len);
                end
            end
            NET_V6_UNSPEC, NET_V6_EXT, NET_V6_NOEXT: begin
                if (w_v6_ok) begin
                    o_res.ok      = 1'b1;
                    o_res.net     = w_v6_net;
                    o_res.l4      = w_v6_l4;
                    o_res.hdr_len = (w_v6_len > 32'hFFFF) ? 16'hFFFF : w_v6_len[15:0];
                end
            end
            default: begin
                o_res.ok = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire
